>>> hw/rtl/gmps_pkg.sv
// grid maze path search: shared types, register indexes and port widths
// no dependencies; imported by the core and by its checker
`default_nettype none

package gmps_pkg;

  localparam int MAX_DIM_DEF = 32;

  localparam int CFG_W  = 6;
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] REG_NUM_ROWS = 1'd0;
  localparam logic [CFG_AW-1:0] REG_NUM_COLS = 1'd1;
  localparam logic [CFG_W-1:0]  DIM_RESET    = 6'd32;

  localparam int IN_TDATA_W  = 8;
  localparam int ROW_IDX_W   = 5;
  localparam int ROW_BITS_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - ROW_IDX_W - ROW_BITS_W;

  localparam logic [2:0] DIR_RIGHT = 3'd0;
  localparam logic [2:0] DIR_DOWN  = 3'd1;
  localparam logic [2:0] DIR_LEFT  = 3'd2;
  localparam logic [2:0] DIR_UP    = 3'd3;

  typedef enum logic [3:0] {
    ST_PRIME,
    ST_LOAD,
    ST_REALIGN,
    ST_DIV,
    ST_INIT,
    ST_STEP,
    ST_CHECK,
    ST_POP,
    ST_MISS,
    ST_OUT_RD,
    ST_OUT_WR
  } gmps_state_e;

endpackage

`default_nettype wire

>>> hw/rtl/grid_maze_path_search_core.sv
// Backtracking maze path search: cells stream in row by row, then a
// depth-first search from the top left to the bottom right corner runs on
// an open map, a path map and a cell stack held in synchronous memories.
// Cells load at one per cycle while no configuration write is pending; a
// prime state comes before the first cell after reset and each answer, and
// a num_rows or num_cols change mid-maze realigns the load position first:
// the loaded cell count is divided by the column count, or loading restarts
// at cell 0 if it is not below the new total. The search is bounded by the
// memory read latency: an in-grid neighbor probe passes a step and a check
// state, an off-grid probe the step state alone and a backtrack a step and
// a pop state; as cells are released when the search backs out of them,
// search time grows with the number of open paths and can be very long on
// wide open mazes. The answer leaves one row at a time, read from the path
// map and then registered while the sink is ready, or as a single not-found
// item. No input is taken during search and answer; the last answer item
// may still wait at the output while the next maze loads. The path map has
// one valid bit per row, so no clearing pass is needed after reset.
`default_nettype none

module grid_maze_path_search_core #(
  parameter int MAX_DIM = gmps_pkg::MAX_DIM_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [gmps_pkg::CFG_AW-1:0]         cfg_addr_i,
  input  wire  [gmps_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [gmps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // cell_open
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [gmps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // row_index, row_bits
  output logic                                m_axis_tlast,
  output logic                                m_axis_tuser    // path_found
);

  import gmps_pkg::*;

  localparam int DimCap     = (MAX_DIM < 32) ? MAX_DIM : 32;
  localparam int RW         = $clog2(DimCap);
  localparam int DW         = $clog2(DimCap + 1);
  localparam int StackDepth = DimCap * DimCap;
  localparam int SpW        = $clog2(StackDepth);
  localparam int CellW      = $clog2(StackDepth + 1);
  localparam int CntW       = $clog2(CellW + 1);

  typedef struct packed {
    logic [RW-1:0] r;
    logic [RW-1:0] c;
    logic [2:0]    dir;
  } ent_t;

  function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DW-1:0] res;
    if (v == '0) begin
      res = DW'(1);
    end else if (int'(v) > DimCap) begin
      res = DW'(DimCap);
    end else begin
      res = DW'(v);
    end
    return res;
  endfunction

  // configuration
  logic [CFG_W-1:0] num_rows_q, num_cols_q;
  logic [DW-1:0]    rows, cols, rows_m1, cols_m1;
  logic [CellW-1:0] total;
  logic [DimCap-1:0] colmask;

  // state
  gmps_state_e state_q, state_d;
  logic [RW-1:0]     ld_r_q, ld_r_d, ld_c_q, ld_c_d;
  logic [CellW-1:0]  ld_cnt_q, ld_cnt_d;
  logic              fresh_q, fresh_d;
  logic [DimCap-1:0] acc_q, acc_d;
  logic              dirty_q, dirty_d;
  logic [CellW-1:0]  dv_q, dv_d, quo_q, quo_d;
  logic [DW:0]       rem_q, rem_d, rem_sh;
  logic [CntW-1:0]   dcnt_q, dcnt_d;
  ent_t              top_q, top_d;
  logic [SpW-1:0]    sp_q, sp_d;
  logic [RW-1:0]     nb_r_q, nb_r_d, nb_c_q, nb_c_d;
  logic [DimCap-1:0] pv_q, pv_d;
  logic [RW-1:0]     k_q, k_d;
  logic              ov_q, ov_d, o_found_q, o_found_d, o_last_q, o_last_d;
  logic [ROW_IDX_W-1:0]  o_row_q, o_row_d;
  logic [ROW_BITS_W-1:0] o_bits_q, o_bits_d;

  // memories
  logic [DimCap-1:0] open_mem [DimCap];
  logic [DimCap-1:0] path_mem [DimCap];
  ent_t              stk_mem  [StackDepth];
  logic [DimCap-1:0] open_rd_q, path_rd_q;
  ent_t              stk_rd_q;
  logic              open_we, path_we, stk_we;
  logic [RW-1:0]     open_waddr, open_raddr, path_waddr, path_raddr;
  logic [DimCap-1:0] open_wdata, path_wdata;
  logic [SpW-1:0]    stk_waddr, stk_raddr;
  ent_t              stk_wdata;

  logic              in_acc, out_free;
  logic [DimCap-1:0] base_word, path_word, nb_path_word;
  logic [RW-1:0]     nr, nc;
  logic              nb_ok;

  assign rows    = eff_dim(num_rows_q);
  assign cols    = eff_dim(num_cols_q);
  assign rows_m1 = rows - DW'(1);
  assign cols_m1 = cols - DW'(1);
  assign total   = CellW'(rows) * CellW'(cols);

  always_comb begin
    for (int j = 0; j < DimCap; j++) begin
      colmask[j] = (j < int'(cols));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= DIM_RESET;
      num_cols_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_NUM_ROWS: num_rows_q <= cfg_wdata_i;
        REG_NUM_COLS: num_cols_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_LOAD) && !dirty_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ov_q || m_axis_tready;

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, o_bits_q, o_row_q};
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tuser  = o_found_q;

  assign base_word    = fresh_q ? open_rd_q : acc_q;
  assign path_word    = pv_q[top_q.r] ? path_rd_q : '0;
  assign nb_path_word = pv_q[nb_r_q] ? path_rd_q : '0;
  assign rem_sh       = {rem_q[DW-1:0], dv_q[CellW-1]};

  // neighbor in the current direction
  always_comb begin
    nr    = top_q.r;
    nc    = top_q.c;
    nb_ok = 1'b0;
    unique case (top_q.dir)
      DIR_RIGHT: begin
        nb_ok = (DW'(top_q.c) + DW'(1)) < cols;
        nc    = top_q.c + RW'(1);
      end
      DIR_DOWN: begin
        nb_ok = (DW'(top_q.r) + DW'(1)) < rows;
        nr    = top_q.r + RW'(1);
      end
      DIR_LEFT: begin
        nb_ok = (top_q.c != '0);
        nc    = top_q.c - RW'(1);
      end
      DIR_UP: begin
        nb_ok = (top_q.r != '0);
        nr    = top_q.r - RW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    ld_r_d    = ld_r_q;
    ld_c_d    = ld_c_q;
    ld_cnt_d  = ld_cnt_q;
    fresh_d   = fresh_q;
    acc_d     = acc_q;
    dirty_d   = dirty_q | cfg_we_i;
    dv_d      = dv_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dcnt_d    = dcnt_q;
    top_d     = top_q;
    sp_d      = sp_q;
    nb_r_d    = nb_r_q;
    nb_c_d    = nb_c_q;
    pv_d      = pv_q;
    k_d       = k_q;
    ov_d      = ov_q && !m_axis_tready;
    o_found_d = o_found_q;
    o_row_d   = o_row_q;
    o_bits_d  = o_bits_q;
    o_last_d  = o_last_q;

    open_we    = 1'b0;
    open_waddr = ld_r_q;
    open_wdata = acc_d;
    path_we    = 1'b0;
    path_waddr = top_q.r;
    path_wdata = '0;
    path_raddr = top_q.r;
    stk_we     = 1'b0;
    stk_waddr  = sp_q;
    stk_wdata  = top_q;
    stk_raddr  = sp_q - SpW'(1);

    unique case (state_q)
      ST_PRIME: begin
        fresh_d = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (dirty_q) begin
          state_d = ST_REALIGN;
        end else if (in_acc) begin
          acc_d          = base_word;
          acc_d[ld_c_q]  = s_axis_tdata[0];
          open_we        = 1'b1;
          open_wdata     = acc_d;
          fresh_d        = 1'b0;
          ld_cnt_d       = ld_cnt_q + CellW'(1);
          ld_c_d         = ld_c_q + RW'(1);
          if (DW'(ld_c_q) == cols_m1) begin
            ld_c_d  = '0;
            fresh_d = 1'b1;
            if (DW'(ld_r_q) == rows_m1) begin
              ld_r_d   = '0;
              ld_cnt_d = '0;
              state_d  = ST_INIT;
            end else begin
              ld_r_d = ld_r_q + RW'(1);
            end
          end
        end
      end
      ST_REALIGN: begin
        if (ld_cnt_q >= total) begin
          ld_cnt_d = '0;
          ld_r_d   = '0;
          ld_c_d   = '0;
          dirty_d  = 1'b0;
          state_d  = ST_PRIME;
        end else begin
          dv_d    = ld_cnt_q;
          quo_d   = '0;
          rem_d   = '0;
          dcnt_d  = CntW'(CellW);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dcnt_q != '0) begin
          dv_d   = dv_q << 1;
          dcnt_d = dcnt_q - CntW'(1);
          if (rem_sh >= {1'b0, cols}) begin
            rem_d = rem_sh - {1'b0, cols};
            quo_d = {quo_q[CellW-2:0], 1'b1};
          end else begin
            rem_d = rem_sh;
            quo_d = {quo_q[CellW-2:0], 1'b0};
          end
        end else begin
          ld_r_d  = quo_q[RW-1:0];
          ld_c_d  = rem_q[RW-1:0];
          dirty_d = 1'b0;
          state_d = ST_PRIME;
        end
      end
      ST_INIT: begin
        path_we    = 1'b1;
        path_waddr = '0;
        path_wdata = DimCap'(1);
        pv_d       = DimCap'(1);
        top_d      = '0;
        sp_d       = '0;
        k_d        = '0;
        if (rows == DW'(1) && cols == DW'(1)) begin
          state_d = ST_OUT_RD;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (top_q.dir[2]) begin
          if (sp_q == '0) begin
            state_d = ST_MISS;
          end else begin
            state_d = ST_POP;
          end
        end else begin
          top_d.dir = top_q.dir + 3'd1;
          if (nb_ok) begin
            nb_r_d     = nr;
            nb_c_d     = nc;
            path_raddr = nr;
            state_d    = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        state_d = ST_STEP;
        if (open_rd_q[nb_c_q] && !nb_path_word[nb_c_q]) begin
          stk_we     = 1'b1;
          sp_d       = sp_q + SpW'(1);
          top_d      = '{r: nb_r_q, c: nb_c_q, dir: DIR_RIGHT};
          path_we    = 1'b1;
          path_waddr = nb_r_q;
          path_wdata = nb_path_word | (DimCap'(1) << nb_c_q);
          pv_d[nb_r_q] = 1'b1;
          if (DW'(nb_r_q) == rows_m1 && DW'(nb_c_q) == cols_m1) begin
            k_d     = '0;
            state_d = ST_OUT_RD;
          end
        end
      end
      ST_POP: begin
        path_we    = 1'b1;
        path_wdata = path_word & ~(DimCap'(1) << top_q.c);
        top_d      = stk_rd_q;
        sp_d       = sp_q - SpW'(1);
        state_d    = ST_STEP;
      end
      ST_MISS: begin
        if (out_free) begin
          ov_d      = 1'b1;
          o_found_d = 1'b0;
          o_row_d   = '0;
          o_bits_d  = '0;
          o_last_d  = 1'b1;
          state_d   = ST_PRIME;
        end
      end
      ST_OUT_RD: begin
        path_raddr = k_q;
        if (out_free) begin
          state_d = ST_OUT_WR;
        end
      end
      ST_OUT_WR: begin
        ov_d      = 1'b1;
        o_found_d = 1'b1;
        o_row_d   = ROW_IDX_W'(k_q);
        o_bits_d  = ROW_BITS_W'((pv_q[k_q] ? path_rd_q : '0) & colmask);
        o_last_d  = (DW'(k_q) == rows_m1);
        k_d       = k_q + RW'(1);
        state_d   = (DW'(k_q) == rows_m1) ? ST_PRIME : ST_OUT_RD;
      end
      default: state_d = ST_PRIME;
    endcase

    open_raddr = (state_q == ST_STEP) ? nr : ld_r_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_PRIME;
      ld_r_q   <= '0;
      ld_c_q   <= '0;
      ld_cnt_q <= '0;
      fresh_q  <= 1'b1;
      dirty_q  <= 1'b0;
      dcnt_q   <= '0;
      sp_q     <= '0;
      pv_q     <= '0;
      k_q      <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      ld_r_q   <= ld_r_d;
      ld_c_q   <= ld_c_d;
      ld_cnt_q <= ld_cnt_d;
      fresh_q  <= fresh_d;
      dirty_q  <= dirty_d;
      dcnt_q   <= dcnt_d;
      sp_q     <= sp_d;
      pv_q     <= pv_d;
      k_q      <= k_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    dv_q      <= dv_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    top_q     <= top_d;
    nb_r_q    <= nb_r_d;
    nb_c_q    <= nb_c_d;
    o_found_q <= o_found_d;
    o_row_q   <= o_row_d;
    o_bits_q  <= o_bits_d;
    o_last_q  <= o_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (open_we) begin
      open_mem[open_waddr] <= open_wdata;
    end
    open_rd_q <= open_mem[open_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (path_we) begin
      path_mem[path_waddr] <= path_wdata;
    end
    path_rd_q <= path_mem[path_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/gmps_checker.sv
// port-level checks for the maze path search core, bound to its top level
// depends on gmps_pkg for port widths
`default_nettype none

module gmps_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              m_axis_tvalid,
  input wire                              m_axis_tready,
  input wire [gmps_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input wire                              m_axis_tlast,
  input wire                              m_axis_tuser
);

  import gmps_pkg::*;

  logic [ROW_IDX_W-1:0] exp_row_q;

  // row index expected on the next result item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_row_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      exp_row_q <= m_axis_tlast ? '0 : m_axis_tdata[ROW_IDX_W-1:0] + ROW_IDX_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  a_miss_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("not-found item is not a single empty last item");

  a_rows_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser)
    else $error("non-last item without a path");

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[ROW_IDX_W-1:0] == exp_row_q)
    else $error("rows of an answer out of order");

endmodule

bind grid_maze_path_search_core gmps_checker u_gmps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
